FILE: hdl/rtrw_pkg.sv
// Shared constants and tables for the ray to rectangle wall distance unit.
// No dependencies; every other file imports this package.
`default_nettype none

package rtrw_pkg;

  localparam int COORD_W = 16;
  localparam int DIST_W = 17;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF = 12;
  localparam int CORDIC_MAX_STEPS = 24;

  // CORDIC datapath widths: Q1.30 vectors and angles in 2^-32 turn.
  localparam int XY_W = 34;
  localparam int Z_W = 34;

  localparam logic [DIST_W-1:0] DIST_MAX = 17'h1FFFF;
  localparam logic [XY_W-1:0] CORDIC_GAIN_Q30 = 34'd652032874;

  // Wall codes as reported on the result.
  localparam logic [1:0] WALL_LEFT = 2'd0;
  localparam logic [1:0] WALL_BOTTOM = 2'd1;
  localparam logic [1:0] WALL_RIGHT = 2'd2;
  localparam logic [1:0] WALL_TOP = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LEFT = 2'd0;
  localparam logic [1:0] CFG_BOTTOM = 2'd1;
  localparam logic [1:0] CFG_RIGHT = 2'd2;
  localparam logic [1:0] CFG_TOP = 2'd3;

  localparam logic [COORD_W-1:0] LEFT_RST = 16'd0;
  localparam logic [COORD_W-1:0] BOTTOM_RST = 16'd0;
  localparam logic [COORD_W-1:0] RIGHT_RST = 16'd20480;
  localparam logic [COORD_W-1:0] TOP_RST = 16'd12288;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURNS [CORDIC_MAX_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

endpackage

`default_nettype wire

FILE: hdl/ray_to_rectangle_wall_distance_unit.sv
// Top level: wall registers, CORDIC cell chain, divider cell chain, final select.
// Depends on rtrw_pkg, rtrw_cordic_cell and rtrw_div_cell.
//
// Gives the distance from a point inside an axis-aligned rectangle to the first
// wall along a heading. One item is accepted per cycle while the output does not
// stall. The inside test, the gaps and the quadrant fold are combinational in front
// of the first CORDIC cell. Each item then passes through CORDIC_STEPS CORDIC cells,
// one rounding stage, 16+FRAC_BITS divider cells (one quotient bit each, x and y side
// by side) and one result register. Every stage has its own valid bit and fills gaps
// when the output stalls.
`default_nettype none

module ray_to_rectangle_wall_distance_unit #(
  parameter int CORDIC_STEPS = rtrw_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS = rtrw_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [rtrw_pkg::COORD_W-1:0]   cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [rtrw_pkg::COORD_W-1:0]   in_pos_x,
  input  wire logic [rtrw_pkg::COORD_W-1:0]   in_pos_y,
  input  wire logic [rtrw_pkg::COORD_W-1:0]   in_heading,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [rtrw_pkg::DIST_W-1:0]         out_distance,
  output logic                                out_outside,
  output logic [1:0]                          out_wall_hit
);
  import rtrw_pkg::*;

  localparam int NUM_W = COORD_W + FRAC_BITS;
  localparam int DEN_W = FRAC_BITS + 2;
  localparam int CS_W = FRAC_BITS + 3;
  localparam int CSIDE_W = 3 + 4 * COORD_W;
  localparam int DSIDE_W = 5;

  // Wall registers.
  logic [COORD_W-1:0] left_r, bottom_r, right_r, top_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= LEFT_RST;
      bottom_r <= BOTTOM_RST;
      right_r <= RIGHT_RST;
      top_r <= TOP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT:   left_r <= cfg_wdata;
        CFG_BOTTOM: bottom_r <= cfg_wdata;
        CFG_RIGHT:  right_r <= cfg_wdata;
        CFG_TOP:    top_r <= cfg_wdata;
        default:    left_r <= left_r;
      endcase
    end
  end

  // Entry: inside test, the four gaps and the quadrant fold.
  logic               outside;
  logic [CSIDE_W-1:0] entry_side;

  always_comb begin
    outside = (in_pos_x < left_r) || (in_pos_x > right_r) ||
              (in_pos_y < bottom_r) || (in_pos_y > top_r);
    entry_side = {outside, in_heading[15:14], right_r - in_pos_x, in_pos_x - left_r,
                  top_r - in_pos_y, in_pos_y - bottom_r};
  end

  logic                   c_valid [CORDIC_STEPS+1];
  logic                   c_ready [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] c_x [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] c_y [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  c_z [CORDIC_STEPS+1];
  logic [CSIDE_W-1:0]     c_side [CORDIC_STEPS+1];

  assign c_valid[0] = in_valid;
  assign in_ready = c_ready[0];
  assign c_x[0] = signed'(CORDIC_GAIN_Q30);
  assign c_y[0] = '0;
  assign c_z[0] = signed'({{(Z_W-30){1'b0}}, in_heading[13:0], 16'b0});
  assign c_side[0] = entry_side;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    rtrw_cordic_cell #(.STEP(i), .SIDE_W(CSIDE_W)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_valid(c_valid[i]), .in_ready(c_ready[i]),
      .in_x(c_x[i]), .in_y(c_y[i]), .in_z(c_z[i]), .in_side(c_side[i]),
      .out_valid(c_valid[i+1]), .out_ready(c_ready[i+1]),
      .out_x(c_x[i+1]), .out_y(c_y[i+1]), .out_z(c_z[i+1]), .out_side(c_side[i+1])
    );
  end

  // Rounding stage: Q1.FRAC_BITS sine and cosine, wall choice and divisor setup.
  logic signed [XY_W-1:0] rx, ry;
  logic signed [CS_W-1:0] cr, sr, cs, sn, cs_abs, sn_abs;
  logic [COORD_W-1:0]     gap_r, gap_l, gap_t, gap_b, gap_x, gap_y;
  logic [1:0]             quad;
  logic                   p_valid_r;
  logic [DEN_W-1:0]       p_den_x_r, p_den_x_nxt, p_den_y_r, p_den_y_nxt;
  logic [NUM_W-1:0]       p_num_x_r, p_num_y_r;
  logic [DSIDE_W-1:0]     p_side_r, p_side_nxt;
  logic                   d_ready [NUM_W+1];

  always_comb begin
    {gap_r, gap_l, gap_t, gap_b} = c_side[CORDIC_STEPS][4*COORD_W-1:0];
    quad = c_side[CORDIC_STEPS][4*COORD_W+1:4*COORD_W];
    rx = (c_x[CORDIC_STEPS] + (XY_W'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    ry = (c_y[CORDIC_STEPS] + (XY_W'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    cr = rx[CS_W-1:0];
    sr = ry[CS_W-1:0];
    case (quad)
      2'd0:    begin cs = cr;  sn = sr;  end
      2'd1:    begin cs = -sr; sn = cr;  end
      2'd2:    begin cs = -cr; sn = -sr; end
      default: begin cs = sr;  sn = -cr; end
    endcase
    cs_abs = cs[CS_W-1] ? -cs : cs;
    sn_abs = sn[CS_W-1] ? -sn : sn;
    p_den_x_nxt = cs_abs[DEN_W-1:0];
    p_den_y_nxt = sn_abs[DEN_W-1:0];
    gap_x = cs[CS_W-1] ? gap_l : gap_r;
    gap_y = sn[CS_W-1] ? gap_b : gap_t;
    // Side: outside, have x, have y, x wall is right, y wall is top.
    p_side_nxt = {c_side[CORDIC_STEPS][CSIDE_W-1], cs != '0, sn != '0,
                  !cs[CS_W-1], !sn[CS_W-1]};
  end

  assign c_ready[CORDIC_STEPS] = !p_valid_r || d_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (c_ready[CORDIC_STEPS]) begin
      p_valid_r <= c_valid[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready[CORDIC_STEPS] && c_valid[CORDIC_STEPS]) begin
      p_den_x_r <= p_den_x_nxt;
      p_den_y_r <= p_den_y_nxt;
      p_num_x_r <= {gap_x, {FRAC_BITS{1'b0}}};
      p_num_y_r <= {gap_y, {FRAC_BITS{1'b0}}};
      p_side_r <= p_side_nxt;
    end
  end

  // Divider chain: one quotient bit per cell.
  logic               d_valid [NUM_W+1];
  logic [DEN_W-1:0]   d_den_x [NUM_W+1];
  logic [DEN_W-1:0]   d_rem_x [NUM_W+1];
  logic [NUM_W-1:0]   d_num_x [NUM_W+1];
  logic [NUM_W-1:0]   d_quo_x [NUM_W+1];
  logic [DEN_W-1:0]   d_den_y [NUM_W+1];
  logic [DEN_W-1:0]   d_rem_y [NUM_W+1];
  logic [NUM_W-1:0]   d_num_y [NUM_W+1];
  logic [NUM_W-1:0]   d_quo_y [NUM_W+1];
  logic [DSIDE_W-1:0] d_side [NUM_W+1];

  assign d_valid[0] = p_valid_r;
  assign d_den_x[0] = p_den_x_r;
  assign d_rem_x[0] = '0;
  assign d_num_x[0] = p_num_x_r;
  assign d_quo_x[0] = '0;
  assign d_den_y[0] = p_den_y_r;
  assign d_rem_y[0] = '0;
  assign d_num_y[0] = p_num_y_r;
  assign d_quo_y[0] = '0;
  assign d_side[0] = p_side_r;

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    rtrw_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(DSIDE_W)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_valid(d_valid[k]), .in_ready(d_ready[k]),
      .in_den_x(d_den_x[k]), .in_rem_x(d_rem_x[k]),
      .in_num_x(d_num_x[k]), .in_quo_x(d_quo_x[k]),
      .in_den_y(d_den_y[k]), .in_rem_y(d_rem_y[k]),
      .in_num_y(d_num_y[k]), .in_quo_y(d_quo_y[k]),
      .in_side(d_side[k]),
      .out_valid(d_valid[k+1]), .out_ready(d_ready[k+1]),
      .out_den_x(d_den_x[k+1]), .out_rem_x(d_rem_x[k+1]),
      .out_num_x(d_num_x[k+1]), .out_quo_x(d_quo_x[k+1]),
      .out_den_y(d_den_y[k+1]), .out_rem_y(d_rem_y[k+1]),
      .out_num_y(d_num_y[k+1]), .out_quo_y(d_quo_y[k+1]),
      .out_side(d_side[k+1])
    );
  end

  // Result stage: saturate, keep the nearer wall (y wins a tie).
  logic              o_valid_r, o_outside_r, o_outside_nxt;
  logic [DIST_W-1:0] o_dist_r, o_dist_nxt, dist_x, dist_y;
  logic [1:0]        o_wall_r, o_wall_nxt, wall_x, wall_y;
  logic              have_x, have_y;

  always_comb begin
    {o_outside_nxt, have_x, have_y} = d_side[NUM_W][4:2];
    wall_x = d_side[NUM_W][1] ? WALL_RIGHT : WALL_LEFT;
    wall_y = d_side[NUM_W][0] ? WALL_TOP : WALL_BOTTOM;
    dist_x = (d_quo_x[NUM_W][NUM_W-1:DIST_W] != '0) ? DIST_MAX
                                                     : d_quo_x[NUM_W][DIST_W-1:0];
    dist_y = (d_quo_y[NUM_W][NUM_W-1:DIST_W] != '0) ? DIST_MAX
                                                     : d_quo_y[NUM_W][DIST_W-1:0];
    if (o_outside_nxt) begin
      o_dist_nxt = '0;
      o_wall_nxt = WALL_LEFT;
    end else if (have_x && (!have_y || dist_x < dist_y)) begin
      o_dist_nxt = dist_x;
      o_wall_nxt = wall_x;
    end else if (have_y) begin
      o_dist_nxt = dist_y;
      o_wall_nxt = wall_y;
    end else begin
      o_dist_nxt = DIST_MAX;
      o_wall_nxt = WALL_LEFT;
    end
  end

  assign d_ready[NUM_W] = !o_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (d_ready[NUM_W]) begin
      o_valid_r <= d_valid[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready[NUM_W] && d_valid[NUM_W]) begin
      o_dist_r <= o_dist_nxt;
      o_outside_r <= o_outside_nxt;
      o_wall_r <= o_wall_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out_distance = o_dist_r;
  assign out_outside = o_outside_r;
  assign out_wall_hit = o_wall_r;

endmodule

`default_nettype wire

FILE: hdl/rtrw_cordic_cell.sv
// One rotation-mode CORDIC iteration with its own pipeline register.
// Depends on rtrw_pkg for the arctangent table.
`default_nettype none

module rtrw_cordic_cell #(
  parameter int STEP = 0,
  parameter int SIDE_W = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [rtrw_pkg::XY_W-1:0] in_x,
  input  wire logic signed [rtrw_pkg::XY_W-1:0] in_y,
  input  wire logic signed [rtrw_pkg::Z_W-1:0]  in_z,
  input  wire logic [SIDE_W-1:0]             in_side,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [rtrw_pkg::XY_W-1:0]   out_x,
  output logic signed [rtrw_pkg::XY_W-1:0]   out_y,
  output logic signed [rtrw_pkg::Z_W-1:0]    out_z,
  output logic [SIDE_W-1:0]                  out_side
);
  import rtrw_pkg::*;

  logic                   valid_r;
  logic signed [XY_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]  z_r, z_nxt, angle;
  logic [SIDE_W-1:0]      side_r;

  assign in_ready = !valid_r || out_ready;

  // Rotate toward zero residual angle; shifts floor.
  always_comb begin
    angle = signed'({{(Z_W-32){1'b0}}, ATAN_TURNS[STEP]});
    if (!in_z[Z_W-1]) begin
      x_nxt = in_x - (in_y >>> STEP);
      y_nxt = in_y + (in_x >>> STEP);
      z_nxt = in_z - angle;
    end else begin
      x_nxt = in_x + (in_y >>> STEP);
      y_nxt = in_y - (in_x >>> STEP);
      z_nxt = in_z + angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_x = x_r;
  assign out_y = y_r;
  assign out_z = z_r;
  assign out_side = side_r;

endmodule

`default_nettype wire

FILE: hdl/rtrw_div_cell.sv
// One restoring-division step for the x and y wall quotients, registered.
// Depends on rtrw_pkg only through the shared import convention.
`default_nettype none

module rtrw_div_cell #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 14,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [DEN_W-1:0]  in_den_x,
  input  wire logic [DEN_W-1:0]  in_rem_x,
  input  wire logic [NUM_W-1:0]  in_num_x,
  input  wire logic [NUM_W-1:0]  in_quo_x,
  input  wire logic [DEN_W-1:0]  in_den_y,
  input  wire logic [DEN_W-1:0]  in_rem_y,
  input  wire logic [NUM_W-1:0]  in_num_y,
  input  wire logic [NUM_W-1:0]  in_quo_y,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DEN_W-1:0]       out_den_x,
  output logic [DEN_W-1:0]       out_rem_x,
  output logic [NUM_W-1:0]       out_num_x,
  output logic [NUM_W-1:0]       out_quo_x,
  output logic [DEN_W-1:0]       out_den_y,
  output logic [DEN_W-1:0]       out_rem_y,
  output logic [NUM_W-1:0]       out_num_y,
  output logic [NUM_W-1:0]       out_quo_y,
  output logic [SIDE_W-1:0]      out_side
);
  import rtrw_pkg::*;

  logic              valid_r;
  logic [DEN_W-1:0]  den_x_r, rem_x_r, rem_x_nxt, den_y_r, rem_y_r, rem_y_nxt;
  logic [NUM_W-1:0]  num_x_r, quo_x_r, quo_x_nxt, num_y_r, quo_y_r, quo_y_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [DEN_W:0]    part_x, part_y;

  assign in_ready = !valid_r || out_ready;

  // Bring down the next dividend bit and subtract when it fits.
  always_comb begin
    part_x = {in_rem_x, in_num_x[NUM_W-1]};
    part_y = {in_rem_y, in_num_y[NUM_W-1]};
    if (part_x >= {1'b0, in_den_x}) begin
      rem_x_nxt = DEN_W'(part_x - {1'b0, in_den_x});
      quo_x_nxt = {in_quo_x[NUM_W-2:0], 1'b1};
    end else begin
      rem_x_nxt = part_x[DEN_W-1:0];
      quo_x_nxt = {in_quo_x[NUM_W-2:0], 1'b0};
    end
    if (part_y >= {1'b0, in_den_y}) begin
      rem_y_nxt = DEN_W'(part_y - {1'b0, in_den_y});
      quo_y_nxt = {in_quo_y[NUM_W-2:0], 1'b1};
    end else begin
      rem_y_nxt = part_y[DEN_W-1:0];
      quo_y_nxt = {in_quo_y[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      den_x_r <= in_den_x;
      rem_x_r <= rem_x_nxt;
      num_x_r <= {in_num_x[NUM_W-2:0], 1'b0};
      quo_x_r <= quo_x_nxt;
      den_y_r <= in_den_y;
      rem_y_r <= rem_y_nxt;
      num_y_r <= {in_num_y[NUM_W-2:0], 1'b0};
      quo_y_r <= quo_y_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_den_x = den_x_r;
  assign out_rem_x = rem_x_r;
  assign out_num_x = num_x_r;
  assign out_quo_x = quo_x_r;
  assign out_den_y = den_y_r;
  assign out_rem_y = rem_y_r;
  assign out_num_y = num_y_r;
  assign out_quo_y = quo_y_r;
  assign out_side = side_r;

endmodule

`default_nettype wire

FILE: sim/tb_ray_to_rectangle_wall_distance_unit.sv
// Self-checking testbench for the ray to rectangle wall distance unit.
// Depends on rtrw_pkg and the unit itself; drives random rays with random idling.
`default_nettype none

module tb_ray_to_rectangle_wall_distance_unit;
  import rtrw_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam int LATENCY = STEPS + FRAC + 19;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_RAYS = 250;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] heading;
  } ray_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic outside;
    logic [1:0] wall_hit;
  } range_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_LEFT;
  logic [COORD_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COORD_W-1:0] in_pos_x = '0;
  logic [COORD_W-1:0] in_pos_y = '0;
  logic [COORD_W-1:0] in_heading = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DIST_W-1:0] out_distance;
  logic out_outside;
  logic [1:0] out_wall_hit;

  // Testbench copy of the wall registers.
  logic [COORD_W-1:0] wall_l = LEFT_RST;
  logic [COORD_W-1:0] wall_b = BOTTOM_RST;
  logic [COORD_W-1:0] wall_r = RIGHT_RST;
  logic [COORD_W-1:0] wall_t = TOP_RST;

  ray_t pending_rays[$];
  range_t expected_ranges[$];
  ray_t cur_ray;
  int send_wait = 0;
  int recv_stall = 0;
  bit no_idle = 0;
  int errors = 0;
  int rays_sent = 0;
  int ranges_seen = 0;
  int outside_seen = 0;
  int cycles = 0;

  ray_to_rectangle_wall_distance_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_heading(in_heading),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_distance(out_distance), .out_outside(out_outside), .out_wall_hit(out_wall_hit)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cosine and sine of a binary angle, quadrant folded, rounded to Q1.FRAC.
  function automatic void heading_cos_sin(input logic [15:0] hd, output longint cs,
                                          output longint sn);
    longint x, y, z, dx, dy, c, s;
    x = longint'(CORDIC_GAIN_Q30);
    y = 0;
    z = longint'(hd[13:0]) <<< 16;
    for (int i = 0; i < STEPS && i < CORDIC_MAX_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_TURNS[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_TURNS[i]);
      end
    end
    c = (x + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
    s = (y + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
    case (hd[15:14])
      2'd0: begin cs = c; sn = s; end
      2'd1: begin cs = -s; sn = c; end
      2'd2: begin cs = -c; sn = -s; end
      default: begin cs = s; sn = -c; end
    endcase
  endfunction

  function automatic longint gap_over_component(input longint gap, input longint comp);
    longint q;
    q = (gap <<< FRAC) / (comp < 0 ? -comp : comp);
    return q > longint'(DIST_MAX) ? longint'(DIST_MAX) : q;
  endfunction

  // Expected range for one ray against the current walls.
  function automatic range_t wall_range(input ray_t r);
    range_t res;
    longint cs, sn, dxw, dyw;
    bit have_x, have_y;
    logic [1:0] wx, wy;
    res = '0;
    have_x = 0; have_y = 0; dxw = 0; dyw = 0; wx = WALL_LEFT; wy = WALL_BOTTOM;
    if (r.pos_x < wall_l || r.pos_x > wall_r || r.pos_y < wall_b || r.pos_y > wall_t) begin
      res.outside = 1'b1;
      return res;
    end
    heading_cos_sin(r.heading, cs, sn);
    if (cs > 0) begin
      have_x = 1; wx = WALL_RIGHT; dxw = gap_over_component(wall_r - r.pos_x, cs);
    end else if (cs < 0) begin
      have_x = 1; wx = WALL_LEFT; dxw = gap_over_component(r.pos_x - wall_l, cs);
    end
    if (sn > 0) begin
      have_y = 1; wy = WALL_TOP; dyw = gap_over_component(wall_t - r.pos_y, sn);
    end else if (sn < 0) begin
      have_y = 1; wy = WALL_BOTTOM; dyw = gap_over_component(r.pos_y - wall_b, sn);
    end
    // On a tie the horizontal wall wins.
    if (have_x && (!have_y || dxw < dyw)) begin
      res.distance = dxw[DIST_W-1:0]; res.wall_hit = wx;
    end else if (have_y) begin
      res.distance = dyw[DIST_W-1:0]; res.wall_hit = wy;
    end else begin
      res.distance = DIST_MAX; res.wall_hit = WALL_LEFT;
    end
    return res;
  endfunction

  // Driver: predicts each accepted item, then presents the next one after a random gap, which may be empty.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_ranges.push_back(wall_range(cur_ray));
        rays_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_rays.size() > 0) begin
          cur_ray = pending_rays.pop_front();
          in_pos_x <= cur_ray.pos_x;
          in_pos_y <= cur_ray.pos_y;
          in_heading <= cur_ray.heading;
          in_valid <= 1'b1;
          send_wait = no_idle ? 0 : $urandom_range(0, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expected range.
  always @(posedge clk) begin
    range_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        ranges_seen++;
        if (out_outside) outside_seen++;
        if (expected_ranges.size() == 0) begin
          $display("%0t: unexpected result distance=%0d outside=%0b wall=%0d", $time,
                   out_distance, out_outside, out_wall_hit);
          errors++;
        end else begin
          exp_r = expected_ranges.pop_front();
          if (exp_r.distance !== out_distance) begin
            $display("%0t: distance expected %0d actual %0d", $time, exp_r.distance,
                     out_distance);
            errors++;
          end
          if (exp_r.outside !== out_outside) begin
            $display("%0t: outside expected %0b actual %0b", $time, exp_r.outside,
                     out_outside);
            errors++;
          end
          if (exp_r.wall_hit !== out_wall_hit) begin
            $display("%0t: wall_hit expected %0d actual %0d", $time, exp_r.wall_hit,
                     out_wall_hit);
            errors++;
          end
        end
        recv_stall = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_ranges.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Waits until the unit has drained and every expected result has come.
  task automatic drain();
    while (pending_rays.size() > 0 || in_valid || expected_ranges.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_wall(input logic [1:0] idx, input logic [COORD_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_LEFT: wall_l = val;
      CFG_BOTTOM: wall_b = val;
      CFG_RIGHT: wall_r = val;
      default: wall_t = val;
    endcase
  endtask

  task automatic set_walls(input int l, input int b, input int r, input int t);
    write_wall(CFG_LEFT, l[15:0]);
    write_wall(CFG_BOTTOM, b[15:0]);
    write_wall(CFG_RIGHT, r[15:0]);
    write_wall(CFG_TOP, t[15:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic ray_t mk_ray(input int x, input int y, input int h);
    ray_t r;
    r.pos_x = x[15:0];
    r.pos_y = y[15:0];
    r.heading = h[15:0];
    return r;
  endfunction

  // Coordinate inside [lo, hi], biased toward the walls.
  function automatic int pick_coord(input int lo, input int hi);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return lo;
    if (sel == 1) return hi;
    return $urandom_range(hi, lo);
  endfunction

  // Heading mostly random, sometimes right at or next to an axis.
  function automatic int pick_heading();
    if ($urandom_range(0, 4) == 0)
      return (16384 * $urandom_range(0, 3) + $urandom_range(0, 6) - 3) & 16'hFFFF;
    return $urandom_range(0, 65535);
  endfunction

  task automatic queue_random_rays(input int n);
    for (int i = 0; i < n; i++) begin
      if (wall_l <= wall_r && wall_b <= wall_t && $urandom_range(0, 9) < 8)
        pending_rays.push_back(mk_ray(pick_coord(wall_l, wall_r),
                                      pick_coord(wall_b, wall_t), pick_heading()));
      else
        pending_rays.push_back(mk_ray($urandom_range(0, 65535), $urandom_range(0, 65535),
                                      $urandom_range(0, 65535)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rays on the reset walls: axes, diagonals, corners, walls, outside points.
    pending_rays.push_back(mk_ray(10240, 6144, 0));
    pending_rays.push_back(mk_ray(10240, 6144, 16384));
    pending_rays.push_back(mk_ray(10240, 6144, 32768));
    pending_rays.push_back(mk_ray(10240, 6144, 49152));
    pending_rays.push_back(mk_ray(10240, 6144, 8192));
    pending_rays.push_back(mk_ray(10240, 6144, 24576));
    pending_rays.push_back(mk_ray(6144, 6144, 40960));
    pending_rays.push_back(mk_ray(6144, 6144, 57344));
    pending_rays.push_back(mk_ray(0, 0, 65535));
    pending_rays.push_back(mk_ray(20480, 12288, 1));
    pending_rays.push_back(mk_ray(0, 12288, 32767));
    pending_rays.push_back(mk_ray(20480, 0, 16383));
    pending_rays.push_back(mk_ray(20481, 6144, 0));
    pending_rays.push_back(mk_ray(10240, 12289, 0));
    pending_rays.push_back(mk_ray(65535, 65535, 65535));
    pending_rays.push_back(mk_ray(0, 0, 0));
    pending_rays.push_back(mk_ray(0, 6144, 32768));
    pending_rays.push_back(mk_ray(10240, 0, 49152));
    drain();

    // Random phases across several wall settings; each boundary drains fully.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_walls(0, 0, 65535, 65535);
        1: set_walls(4096, 4096, 4096, 4096);
        2: set_walls(30000, 100, 20000, 200);
        3: set_walls(65535, 65535, 65535, 65535);
        4: set_walls(100, 50, 65535, 300);
        default: set_walls($urandom_range(0, 20000), $urandom_range(0, 20000),
                           $urandom_range(20000, 65535), $urandom_range(20000, 65535));
      endcase
      no_idle = (ph == 2);
      queue_random_rays(PHASE_RAYS);
      drain();
    end

    $display("%0d rays checked (%0d with origin outside) over six wall settings,",
             ranges_seen, outside_seen);
    $display("with random source gaps and sink stalls; %0d mismatches", errors);
    if (errors == 0 && expected_ranges.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
hdl/rtrw_pkg.sv
hdl/rtrw_cordic_cell.sv
hdl/rtrw_div_cell.sv
hdl/ray_to_rectangle_wall_distance_unit.sv
sim/tb_ray_to_rectangle_wall_distance_unit.sv
